>>> hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the inverse core; they expand to nothing when
// the synthesis flow defines SYNTHESIS.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define M3_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
// expression must never be true outside reset
`define M3_NEVER(lbl, expr, msg) \
    `M3_ASSERT(lbl, !(expr), msg)
`else
`define M3_ASSERT(lbl, prop, msg)
`define M3_NEVER(lbl, expr, msg)
`endif
`endif

>>> hdl/m3inv_pkg.sv
// ---------------------------------------------------------------------------
// m3inv_pkg
// Widths, cofactor index table and payload types of the 3x3 inverse core.
// ---------------------------------------------------------------------------
package m3inv_pkg;

    // entry format
    localparam int ENTRY_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int NUM_ENT     = 9;

    // derived widths
    localparam int PW   = 2 * ENTRY_WIDTH;          // 2x2 product
    localparam int CW   = 2 * ENTRY_WIDTH + 1;      // signed cofactor
    localparam int CMW  = 2 * ENTRY_WIDTH;          // cofactor magnitude
    localparam int HW   = CW - ENTRY_WIDTH;         // upper cofactor slice
    localparam int PPW  = ENTRY_WIDTH + HW;         // determinant partial product
    localparam int DW   = ENTRY_WIDTH + CW + 2;     // signed determinant
    localparam int SH   = 2 * FRAC_BITS;            // numerator scaling
    localparam int NW   = CMW + SH;                 // scaled numerator
    localparam int TW   = NW - ENTRY_WIDTH;         // numerator above quotient bits
    localparam int RW   = DW + 1;                   // divider remainder
    localparam int CMPW = (TW > RW) ? TW : RW;

    // pipeline depths
    localparam int FRONT_STAGES = 6;
    localparam int BACK_STAGES  = ENTRY_WIDTH + 2;

    // cofactor k = a[p0]*a[p1] - a[q0]*a[q1], adjugate in output order
    localparam logic [3:0] COF_IDX [NUM_ENT][4] = '{
        '{4'd4, 4'd8, 4'd5, 4'd7},
        '{4'd7, 4'd2, 4'd1, 4'd8},
        '{4'd1, 4'd5, 4'd4, 4'd2},
        '{4'd6, 4'd5, 4'd3, 4'd8},
        '{4'd0, 4'd8, 4'd6, 4'd2},
        '{4'd3, 4'd2, 4'd0, 4'd5},
        '{4'd3, 4'd7, 4'd6, 4'd4},
        '{4'd6, 4'd1, 4'd0, 4'd7},
        '{4'd0, 4'd4, 4'd3, 4'd1}
    };

    typedef logic [NUM_ENT-1:0][ENTRY_WIDTH-1:0] t_ent_vec;
    typedef logic [NUM_ENT-1:0][CW-1:0]          t_cof_vec;

    // front to back transaction
    typedef struct packed {
        t_cof_vec        cof;
        logic [DW-1:0]   det;
    } t_mid;

    // result transaction
    typedef struct packed {
        t_ent_vec ent;
        logic     singular;
        logic     overflow;
    } t_res;

endpackage

>>> hdl/m3inv_front.sv
// ---------------------------------------------------------------------------
// m3inv_front
// Accepts matrices and forms the nine exact cofactors and the determinant.
// ---------------------------------------------------------------------------
module m3inv_front import m3inv_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    output logic     o_full,
    input  t_ent_vec i_ent,
    output logic     o_mq_push,
    output t_mid     o_mq_data,
    input  logic     i_mq_full
);

    logic                     en;
    logic [FRONT_STAGES-1:0]  r_v;

    logic signed [PW-1:0]          n_p [2*NUM_ENT];
    logic signed [PW-1:0]          r_p [2*NUM_ENT];
    logic signed [ENTRY_WIDTH-1:0] r_a1 [3];
    logic signed [ENTRY_WIDTH-1:0] r_a2 [3];
    t_cof_vec                      n_c;
    t_cof_vec                      r_c2, r_c3, r_c4, r_c5, r_c6;
    logic signed [PPW-1:0]         n_hi [3];
    logic signed [PPW-1:0]         n_lo [3];
    logic signed [PPW-1:0]         r_hi [3];
    logic signed [PPW-1:0]         r_lo [3];
    logic signed [DW-1:0]          n_t [3];
    logic signed [DW-1:0]          r_t [3];
    logic signed [DW-1:0]          r_s, r_t2, r_det;

    // pipeline moves whenever its last stage can leave
    assign en        = !r_v[FRONT_STAGES-1] || !i_mq_full;
    assign o_full    = !en;
    assign o_mq_push = r_v[FRONT_STAGES-1] && !i_mq_full;
    assign o_mq_data = '{cof: r_c6, det: r_det};

    // stage 1: eighteen 2x2 products
    always_comb begin
        for (int k = 0; k < NUM_ENT; k++) begin
            n_p[2*k]   = $signed(i_ent[COF_IDX[k][0]]) * $signed(i_ent[COF_IDX[k][1]]);
            n_p[2*k+1] = $signed(i_ent[COF_IDX[k][2]]) * $signed(i_ent[COF_IDX[k][3]]);
        end
    end

    // stage 2: cofactor differences
    always_comb begin
        for (int k = 0; k < NUM_ENT; k++) begin
            n_c[k] = $signed({r_p[2*k][PW-1], r_p[2*k]})
                   - $signed({r_p[2*k+1][PW-1], r_p[2*k+1]});
        end
    end

    // stage 3: first-row entries times cofactors, split in two partial products
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            n_hi[j] = r_a2[j] * $signed(r_c2[3*j][CW-1:ENTRY_WIDTH]);
            n_lo[j] = r_a2[j] * $signed({1'b0, r_c2[3*j][ENTRY_WIDTH-1:0]});
        end
    end

    // stage 4: recombine partial products
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            n_t[j] = $signed({{(DW-PPW-ENTRY_WIDTH){r_hi[j][PPW-1]}}, r_hi[j],
                              {ENTRY_WIDTH{1'b0}}})
                   + $signed({{(DW-PPW){r_lo[j][PPW-1]}}, r_lo[j]});
        end
    end

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[FRONT_STAGES-2:0], i_push};
        end
    end

    // payload stages
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 2*NUM_ENT; k++) begin
                r_p[k] <= n_p[k];
            end
            for (int j = 0; j < 3; j++) begin
                r_a1[j] <= $signed(i_ent[j]);
                r_a2[j] <= r_a1[j];
                r_hi[j] <= n_hi[j];
                r_lo[j] <= n_lo[j];
                r_t[j]  <= n_t[j];
            end
            r_c2  <= n_c;
            r_c3  <= r_c2;
            r_c4  <= r_c3;
            r_c5  <= r_c4;
            r_c6  <= r_c5;
            r_s   <= r_t[0] + r_t[1];
            r_t2  <= r_t[2];
            r_det <= r_s + r_t2;
        end
    end

endmodule

>>> hdl/m3inv_link.sv
// ---------------------------------------------------------------------------
// m3inv_link
// Two-entry queue between the cofactor front and the divider back.
// ---------------------------------------------------------------------------
module m3inv_link import m3inv_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_mid i_data,
    output logic o_full,
    output logic o_valid,
    output t_mid o_data,
    input  logic i_pop
);

    t_mid       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       do_push, do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) r_wp <= !r_wp;
            if (do_pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

>>> hdl/m3inv_back.sv
// ---------------------------------------------------------------------------
// m3inv_back
// Nine pipelined restoring dividers, saturation and the result queue.
// ---------------------------------------------------------------------------
module m3inv_back import m3inv_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_mq_valid,
    input  t_mid i_mq_data,
    output logic o_mq_pop,
    output logic o_empty,
    output t_res o_res,
    input  logic i_pop
);

    localparam int EW = ENTRY_WIDTH;

    logic                    en;
    logic [BACK_STAGES-1:0]  r_v;

    // divider pipeline, index 0 is the set-up stage
    logic [RW-1:0]      r_rem [EW+1][NUM_ENT];
    logic [EW-1:0]      r_nlo [EW+1][NUM_ENT];
    logic [EW-1:0]      r_q   [EW+1][NUM_ENT];
    logic [DW-1:0]      r_d   [EW+1];
    logic [NUM_ENT-1:0] r_neg [EW+1];
    logic [NUM_ENT-1:0] r_big [EW+1];
    logic               r_sing [EW+1];

    logic [RW-1:0]      n_rem [EW+1][NUM_ENT];
    logic [EW-1:0]      n_nlo [EW+1][NUM_ENT];
    logic [EW-1:0]      n_q   [EW+1][NUM_ENT];
    logic [NUM_ENT-1:0] n_neg, n_big;
    logic [DW-1:0]      n_d;
    logic               dneg;
    logic [CW-1:0]      cabs;
    logic [NW-1:0]      num;
    logic [RW-1:0]      trial;
    logic               ge;
    t_res               n_res, r_res;

    // result queue
    t_res       r_oq [2];
    logic       r_oq_wp, r_oq_rp;
    logic [1:0] r_oq_cnt;
    logic       oq_full, oq_push, oq_pop;

    assign oq_full  = (r_oq_cnt == 2'd2);
    assign en       = !r_v[BACK_STAGES-1] || !oq_full;
    assign o_mq_pop = i_mq_valid && en;
    assign oq_push  = r_v[BACK_STAGES-1] && !oq_full;
    assign o_empty  = (r_oq_cnt == 2'd0);
    assign oq_pop   = i_pop && !o_empty;
    assign o_res    = r_oq[r_oq_rp];

    // set-up: magnitudes, signs, early overflow test, first remainder;
    // then one quotient bit per stage and lane
    always_comb begin
        dneg = i_mq_data.det[DW-1];
        n_d  = dneg ? (~i_mq_data.det + 1'b1) : i_mq_data.det;
        for (int l = 0; l < NUM_ENT; l++) begin
            cabs = i_mq_data.cof[l][CW-1] ? (~i_mq_data.cof[l] + 1'b1) : i_mq_data.cof[l];
            num  = {cabs[CMW-1:0], {SH{1'b0}}};
            n_neg[l] = i_mq_data.cof[l][CW-1] ^ dneg;
            n_big[l] = CMPW'(num[NW-1:EW]) >= CMPW'(n_d);
            n_rem[0][l] = n_big[l] ? '0 : RW'(num[NW-1:EW]);
            n_nlo[0][l] = num[EW-1:0];
            n_q[0][l]   = '0;
        end
        for (int k = 1; k <= EW; k++) begin
            for (int l = 0; l < NUM_ENT; l++) begin
                trial = {r_rem[k-1][l][RW-2:0], r_nlo[k-1][l][EW-1]};
                ge    = trial >= RW'(r_d[k-1]);
                n_rem[k][l] = ge ? (trial - RW'(r_d[k-1])) : trial;
                n_nlo[k][l] = {r_nlo[k-1][l][EW-2:0], 1'b0};
                n_q[k][l]   = {r_q[k-1][l][EW-2:0], ge};
            end
        end
    end

    // sign, saturation and the singular case
    always_comb begin
        n_res.singular = r_sing[EW];
        n_res.overflow = 1'b0;
        for (int l = 0; l < NUM_ENT; l++) begin
            if (r_sing[EW]) begin
                n_res.ent[l] = '0;
            end else if (r_neg[EW][l]) begin
                if (r_big[EW][l] || (r_q[EW][l] > {1'b1, {(EW-1){1'b0}}})) begin
                    n_res.ent[l]   = {1'b1, {(EW-1){1'b0}}};
                    n_res.overflow = 1'b1;
                end else begin
                    n_res.ent[l] = ~r_q[EW][l] + 1'b1;
                end
            end else begin
                if (r_big[EW][l] || r_q[EW][l][EW-1]) begin
                    n_res.ent[l]   = {1'b0, {(EW-1){1'b1}}};
                    n_res.overflow = 1'b1;
                end else begin
                    n_res.ent[l] = r_q[EW][l];
                end
            end
        end
    end

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[BACK_STAGES-2:0], i_mq_valid};
        end
    end

    // divider payload
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d[0]    <= n_d;
            r_neg[0]  <= n_neg;
            r_big[0]  <= n_big;
            r_sing[0] <= (i_mq_data.det == '0);
            for (int k = 0; k <= EW; k++) begin
                for (int l = 0; l < NUM_ENT; l++) begin
                    r_rem[k][l] <= n_rem[k][l];
                    r_nlo[k][l] <= n_nlo[k][l];
                    r_q[k][l]   <= n_q[k][l];
                end
            end
            for (int k = 1; k <= EW; k++) begin
                r_d[k]    <= r_d[k-1];
                r_neg[k]  <= r_neg[k-1];
                r_big[k]  <= r_big[k-1];
                r_sing[k] <= r_sing[k-1];
            end
            r_res <= n_res;
        end
    end

    // result queue control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oq_wp  <= 1'b0;
            r_oq_rp  <= 1'b0;
            r_oq_cnt <= 2'd0;
        end else begin
            if (oq_push) r_oq_wp <= !r_oq_wp;
            if (oq_pop)  r_oq_rp <= !r_oq_rp;
            r_oq_cnt <= r_oq_cnt + {1'b0, oq_push} - {1'b0, oq_pop};
        end
    end

    // result queue storage
    always_ff @(posedge i_clk) begin
        if (oq_push) begin
            r_oq[r_oq_wp] <= r_res;
        end
    end

endmodule

>>> hdl/matrix3_inverse_core.sv
// ---------------------------------------------------------------------------
// matrix3_inverse_core
// Inverse of a signed Q16.16 3x3 matrix through the exact adjugate.
// ---------------------------------------------------------------------------
// Input side is a queue: drive the nine entries with push high; the matrix
// is taken at an edge where full is low. Result side is a queue too: while
// empty is low the oldest inverse sits on the o_out ports with its singular
// and overflow flags, and it leaves at an edge where pop is high.
// A six-stage front forms the nine cofactors and the determinant and hands
// them through a two-entry queue to the back, where nine restoring dividers
// produce one quotient bit per stage over 32 stages, followed by a
// saturation stage and a two-entry result queue.
// One matrix is accepted per cycle while results are popped each cycle;
// the pipeline depths of front and back and the queues set the latency.
// When pop stays low the back pipeline stops once its result queue fills,
// the link queue then fills, and full rises; nothing is dropped.
// Reset empties all pipelines and queues; no result is pending after it.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"
module matrix3_inverse_core import m3inv_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic signed [ENTRY_WIDTH-1:0] i_in_r0c0,
    input  logic signed [ENTRY_WIDTH-1:0] i_in_r0c1,
    input  logic signed [ENTRY_WIDTH-1:0] i_in_r0c2,
    input  logic signed [ENTRY_WIDTH-1:0] i_in_r1c0,
    input  logic signed [ENTRY_WIDTH-1:0] i_in_r1c1,
    input  logic signed [ENTRY_WIDTH-1:0] i_in_r1c2,
    input  logic signed [ENTRY_WIDTH-1:0] i_in_r2c0,
    input  logic signed [ENTRY_WIDTH-1:0] i_in_r2c1,
    input  logic signed [ENTRY_WIDTH-1:0] i_in_r2c2,
    output logic                          empty,
    input  logic                          pop,
    output logic signed [ENTRY_WIDTH-1:0] o_out_r0c0,
    output logic signed [ENTRY_WIDTH-1:0] o_out_r0c1,
    output logic signed [ENTRY_WIDTH-1:0] o_out_r0c2,
    output logic signed [ENTRY_WIDTH-1:0] o_out_r1c0,
    output logic signed [ENTRY_WIDTH-1:0] o_out_r1c1,
    output logic signed [ENTRY_WIDTH-1:0] o_out_r1c2,
    output logic signed [ENTRY_WIDTH-1:0] o_out_r2c0,
    output logic signed [ENTRY_WIDTH-1:0] o_out_r2c1,
    output logic signed [ENTRY_WIDTH-1:0] o_out_r2c2,
    output logic                          o_singular,
    output logic                          o_overflow
);

    t_ent_vec w_ent;
    t_mid     w_f_data, w_l_data;
    logic     w_f_push, w_l_full, w_l_valid, w_l_pop;
    t_res     w_res;
    logic     w_sat_any;

    // pack entries in row-major order
    assign w_ent = {i_in_r2c2, i_in_r2c1, i_in_r2c0,
                    i_in_r1c2, i_in_r1c1, i_in_r1c0,
                    i_in_r0c2, i_in_r0c1, i_in_r0c0};

    // cofactor and determinant front
    m3inv_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .o_full    (full),
        .i_ent     (w_ent),
        .o_mq_push (w_f_push),
        .o_mq_data (w_f_data),
        .i_mq_full (w_l_full)
    );

    // decoupling queue
    m3inv_link u_link (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_f_push),
        .i_data  (w_f_data),
        .o_full  (w_l_full),
        .o_valid (w_l_valid),
        .o_data  (w_l_data),
        .i_pop   (w_l_pop)
    );

    // divider back end
    m3inv_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_mq_valid (w_l_valid),
        .i_mq_data  (w_l_data),
        .o_mq_pop   (w_l_pop),
        .o_empty    (empty),
        .o_res      (w_res),
        .i_pop      (pop)
    );

    // unpack result
    assign o_out_r0c0 = $signed(w_res.ent[0]);
    assign o_out_r0c1 = $signed(w_res.ent[1]);
    assign o_out_r0c2 = $signed(w_res.ent[2]);
    assign o_out_r1c0 = $signed(w_res.ent[3]);
    assign o_out_r1c1 = $signed(w_res.ent[4]);
    assign o_out_r1c2 = $signed(w_res.ent[5]);
    assign o_out_r2c0 = $signed(w_res.ent[6]);
    assign o_out_r2c1 = $signed(w_res.ent[7]);
    assign o_out_r2c2 = $signed(w_res.ent[8]);
    assign o_singular = w_res.singular;
    assign o_overflow = w_res.overflow;

    // any entry at a saturation limit
    always_comb begin
        w_sat_any = 1'b0;
        for (int l = 0; l < NUM_ENT; l++) begin
            if ((w_res.ent[l] == {1'b0, {(ENTRY_WIDTH-1){1'b1}}})
                || (w_res.ent[l] == {1'b1, {(ENTRY_WIDTH-1){1'b0}}})) begin
                w_sat_any = 1'b1;
            end
        end
    end

    // checks
    `M3_NEVER(a_sing_ovf, !empty && o_singular && (o_overflow || (w_res.ent != '0)), "singular result not clean")
    `M3_ASSERT(a_ovf_sat, (!empty && o_overflow) |-> w_sat_any, "overflow without saturated entry")
    `M3_ASSERT(a_full_link, full |-> w_l_full, "front stalled while link queue has room")

endmodule

>>> tb/matrix3_inverse_core_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// matrix3_inverse_core_tb
// Streams 3x3 Q16.16 matrices into the inverse core with random gaps on both
// sides. Each accepted matrix is inverted by an exact wide-integer model in
// the bench, and every popped inverse is compared entry by entry, together
// with its singular and overflow flags.
// ---------------------------------------------------------------------------
module matrix3_inverse_core_tb;
    import m3inv_pkg::*;

    typedef logic signed [ENTRY_WIDTH-1:0] t_entry;

    typedef struct {
        t_entry ent [NUM_ENT];
        logic   singular;
        logic   overflow;
    } t_inverse;

    localparam int N_RANDOM = 1800;

    logic   i_clk;
    logic   i_rst_n;
    logic   push;
    logic   full;
    logic   empty;
    logic   pop;
    t_entry mat_drv [NUM_ENT];
    t_entry inv_out [NUM_ENT];
    logic   o_singular;
    logic   o_overflow;

    t_inverse inverse_q [$];
    int       mismatch_cnt;
    int       hold_cycles;
    bit       rx_no_idle;
    bit       tx_no_idle;

    // clock, 10 ns period
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    matrix3_inverse_core u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_in_r0c0  (mat_drv[0]),
        .i_in_r0c1  (mat_drv[1]),
        .i_in_r0c2  (mat_drv[2]),
        .i_in_r1c0  (mat_drv[3]),
        .i_in_r1c1  (mat_drv[4]),
        .i_in_r1c2  (mat_drv[5]),
        .i_in_r2c0  (mat_drv[6]),
        .i_in_r2c1  (mat_drv[7]),
        .i_in_r2c2  (mat_drv[8]),
        .empty      (empty),
        .pop        (pop),
        .o_out_r0c0 (inv_out[0]),
        .o_out_r0c1 (inv_out[1]),
        .o_out_r0c2 (inv_out[2]),
        .o_out_r1c0 (inv_out[3]),
        .o_out_r1c1 (inv_out[4]),
        .o_out_r1c2 (inv_out[5]),
        .o_out_r2c0 (inv_out[6]),
        .o_out_r2c1 (inv_out[7]),
        .o_out_r2c2 (inv_out[8]),
        .o_singular (o_singular),
        .o_overflow (o_overflow)
    );

    // exact adjugate inverse, truncated toward zero and saturated
    function automatic t_inverse invert_matrix(input t_entry m [NUM_ENT]);
        logic signed [67:0]  a [NUM_ENT];
        logic signed [67:0]  cf [NUM_ENT];
        logic signed [127:0] det;
        logic [191:0]        num_mag;
        logic [191:0]        den_mag;
        logic [191:0]        quo;
        logic [191:0]        lim;
        bit                  neg;
        t_inverse            r;
        for (int i = 0; i < NUM_ENT; i++) a[i] = m[i];
        cf[0] = a[4] * a[8] - a[5] * a[7];
        cf[1] = a[7] * a[2] - a[1] * a[8];
        cf[2] = a[1] * a[5] - a[4] * a[2];
        cf[3] = a[6] * a[5] - a[3] * a[8];
        cf[4] = a[0] * a[8] - a[6] * a[2];
        cf[5] = a[3] * a[2] - a[0] * a[5];
        cf[6] = a[3] * a[7] - a[6] * a[4];
        cf[7] = a[6] * a[1] - a[0] * a[7];
        cf[8] = a[0] * a[4] - a[3] * a[1];
        det = 128'(a[0]) * 128'(cf[0]) + 128'(a[1]) * 128'(cf[3])
            + 128'(a[2]) * 128'(cf[6]);
        r.overflow = 1'b0;
        r.singular = (det == 0);
        if (r.singular) begin
            for (int i = 0; i < NUM_ENT; i++) r.ent[i] = '0;
            return r;
        end
        den_mag = (det < 0) ? 192'(-det) : 192'(det);
        lim     = 192'(1) << (ENTRY_WIDTH - 1);
        for (int i = 0; i < NUM_ENT; i++) begin
            num_mag = (cf[i] < 0) ? 192'(-cf[i]) : 192'(cf[i]);
            num_mag = num_mag << (2 * FRAC_BITS);
            neg     = (cf[i] < 0) != (det < 0);
            quo     = num_mag / den_mag;
            if (neg) begin
                if (quo > lim) begin
                    quo = lim;
                    r.overflow = 1'b1;
                end
                r.ent[i] = t_entry'(-quo);
            end else begin
                if (quo > lim - 1) begin
                    quo = lim - 1;
                    r.overflow = 1'b1;
                end
                r.ent[i] = t_entry'(quo);
            end
        end
        return r;
    endfunction

    // short gaps mostly, a few long ones
    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 60) return 0;
        if (p < 95) return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    // offer one matrix and wait for the transaction to complete
    task automatic send_matrix(input t_entry m [NUM_ENT]);
        int gap;
        gap = tx_no_idle ? 0 : pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            push <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        push <= 1'b1;
        for (int i = 0; i < NUM_ENT; i++) mat_drv[i] <= m[i];
        do @(posedge i_clk); while (full);
        inverse_q.push_back(invert_matrix(m));
    endtask

    task automatic send_idle();
        @(negedge i_clk);
        push <= 1'b0;
    endtask

    // random entry: full range, moderate Q16.16, near-edge or tiny values
    function automatic t_entry rand_entry(input int mode);
        case (mode)
            0: return t_entry'($urandom);
            1: return t_entry'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
            2: return $urandom_range(0, 1) ? 32'sh7fff_ffff - $urandom_range(0, 3)
                                           : 32'sh8000_0000 + $urandom_range(0, 3);
            default: return t_entry'($signed($urandom_range(0, 64)) - 32);
        endcase
    endfunction

    task automatic test_directed();
        t_entry m [NUM_ENT];
        // identity and scaled identities
        foreach (m[i]) m[i] = (i % 4 == 0) ? 32'sh0001_0000 : '0;
        send_matrix(m);
        foreach (m[i]) m[i] = (i % 4 == 0) ? -32'sh0002_0000 : '0;
        send_matrix(m);
        // tiny diagonal saturates positive and negative
        foreach (m[i]) m[i] = (i % 4 == 0) ? 32'sh1 : '0;
        send_matrix(m);
        foreach (m[i]) m[i] = (i % 4 == 0) ? -32'sh1 : '0;
        send_matrix(m);
        // extreme diagonals
        foreach (m[i]) m[i] = (i % 4 == 0) ? 32'sh8000_0000 : '0;
        send_matrix(m);
        foreach (m[i]) m[i] = (i % 4 == 0) ? 32'sh7fff_ffff : '0;
        send_matrix(m);
        // zero determinant cases
        foreach (m[i]) m[i] = '0;
        send_matrix(m);
        foreach (m[i]) m[i] = 32'sh8000_0000;
        send_matrix(m);
        foreach (m[i]) m[i] = 32'sh7fff_ffff;
        send_matrix(m);
        foreach (m[i]) m[i] = '1;
        send_matrix(m);
        // mixed extremes off the diagonal
        foreach (m[i]) m[i] = (i % 2) ? 32'sh8000_0000 : 32'sh7fff_ffff;
        send_matrix(m);
        foreach (m[i]) m[i] = (i % 4 == 0) ? 32'sh8000_0000 : 32'sh7fff_ffff;
        send_matrix(m);
        // general well-conditioned matrix
        m = '{32'sh0002_0000, 32'sh0001_0000, '0, 32'sh0001_0000, 32'sh0003_0000,
              32'sh0001_0000, '0, 32'sh0001_0000, 32'sh0004_0000};
        send_matrix(m);
        // zero cofactor with negative determinant
        m = '{-32'sh0001_0000, '0, '0, '0, 32'sh0001_0000, '0, '0, '0, 32'sh0001_0000};
        send_matrix(m);
        for (int k = 0; k < 6; k++) begin
            foreach (m[i]) m[i] = rand_entry(0);
            send_matrix(m);
        end
        send_idle();
    endtask

    task automatic test_random_mix();
        t_entry m [NUM_ENT];
        int     kind;
        for (int n = 0; n < N_RANDOM; n++) begin
            // stretches with no idling on either side
            tx_no_idle = (n >= 600 && n < 800);
            rx_no_idle = (n >= 600 && n < 800);
            kind = $urandom_range(0, 9);
            foreach (m[i]) m[i] = rand_entry((kind < 4) ? 1 : (kind < 6) ? 0 :
                                             (kind < 7) ? 2 : 3);
            if (kind == 8) begin
                // dependent rows
                m[6] = m[0];
                m[7] = m[1];
                m[8] = m[2];
            end else if (kind == 9) begin
                // dominant diagonal
                m[0] = 32'sh0010_0000;
                m[4] = -32'sh0010_0000;
                m[8] = 32'sh0010_0000;
            end
            send_matrix(m);
        end
        tx_no_idle = 0;
        rx_no_idle = 0;
        send_idle();
    endtask

    task automatic test_backpressure();
        t_entry m [NUM_ENT];
        hold_cycles = 300;
        tx_no_idle  = 1;
        for (int n = 0; n < 80; n++) begin
            foreach (m[i]) m[i] = rand_entry(1);
            send_matrix(m);
        end
        tx_no_idle = 0;
        send_idle();
    endtask

    // result side: pop pattern with random gaps and a requested hold-off
    initial begin
        int stall_left;
        stall_left = 0;
        pop = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                pop <= 1'b0;
            end else if (rx_no_idle) begin
                pop <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                pop <= 1'b0;
            end else if ($urandom_range(0, 49) == 0) begin
                stall_left = $urandom_range(10, 60);
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(0, 3) != 0);
            end
        end
    end

    // result check on each popped transaction
    always @(posedge i_clk) begin
        t_inverse exp_inv;
        bit       bad;
        if (i_rst_n && pop && !empty) begin
            if (inverse_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10) $display("unexpected result transaction");
            end else begin
                exp_inv = inverse_q.pop_front();
                bad = (o_singular !== exp_inv.singular) || (o_overflow !== exp_inv.overflow);
                for (int i = 0; i < NUM_ENT; i++) bad |= (inv_out[i] !== exp_inv.ent[i]);
                if (bad) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10) begin
                        $display("mismatch: singular %b/%b overflow %b/%b (exp/act)",
                                 exp_inv.singular, o_singular, exp_inv.overflow, o_overflow);
                        for (int i = 0; i < NUM_ENT; i++)
                            $display("  entry %0d exp %h act %h", i, exp_inv.ent[i], inv_out[i]);
                    end
                end
            end
        end
    end

    // run limit
    initial begin
        #20ms;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        mismatch_cnt = 0;
        hold_cycles  = 0;
        rx_no_idle   = 0;
        tx_no_idle   = 0;
        i_rst_n      = 1'b0;
        push         = 1'b0;
        foreach (mat_drv[i]) mat_drv[i] = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_backpressure();
        test_random_mix();

        // drain and let the pipeline settle
        while (inverse_q.size() != 0) @(posedge i_clk);
        repeat (FRONT_STAGES + BACK_STAGES + 20) @(posedge i_clk);
        if (mismatch_cnt == 0 && inverse_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
